[src/hcbc_pkg.sv]
// Shared types and constants for the HSV color blob centroid unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hcbc_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int NUM_CLASSES    = 4;
  localparam int CLS_IDX_W      = 2;

  localparam int CFG_W      = 12;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  localparam int SUM_W   = 33;
  localparam int TALLY_W = 23;
  localparam int CENT_W  = 11;
  localparam int QDEPTH  = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_BLUE   = 3'd1,
    CLS_GREEN  = 3'd2,
    CLS_RED    = 3'd3,
    CLS_YELLOW = 3'd4
  } cls_t;

  typedef enum logic {
    KIND_PIXEL    = 1'b0,
    KIND_CENTROID = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    cls_t cls;
    logic frame_end;
  } pix_info_t;

endpackage

`default_nettype wire

[src/hcbc_front.sv]
// Front end: pixel classification, raster position tracking and size registers.
// Depends on hcbc_pkg; pushes one request per pixel into the queue.
`default_nettype none

module hcbc_front #(
  parameter int MAX_WIDTH  = hcbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hcbc_pkg::MAX_HEIGHT_DEF,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire  [hcbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [hcbc_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [hcbc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                               q_full,
  output logic                              q_push,
  output hcbc_pkg::pix_info_t               q_info,
  output logic [CW-1:0]                     q_col,
  output logic [RW-1:0]                     q_row
);
  import hcbc_pkg::*;

  localparam int CWX = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int RWX = (CFG_W > RW + 1) ? CFG_W : RW + 1;

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CWX-1:0]   w_eff, col_plus;
  logic [RWX-1:0]   h_eff, row_plus;
  logic [7:0]       hue, sat, bri;
  logic             row_end, frame_end;
  cls_t             cls;

  function automatic cls_t classify(input logic [7:0] h, input logic [7:0] s,
                                    input logic [7:0] v);
    cls_t c;
    c = CLS_NONE;
    if (v > 8'd64) begin
      if (h > 8'd90 && h < 8'd110 && s > 8'd120) begin
        c = CLS_BLUE;
      end else if (h > 8'd60 && h < 8'd80 && s > 8'd120) begin
        c = CLS_GREEN;
      end else if (((h > 8'd0 && h < 8'd5) || (h > 8'd160 && h < 8'd180)) &&
                   s > 8'd110) begin
        c = CLS_RED;
      end else if (h > 8'd20 && h < 8'd30 && s > 8'd160) begin
        c = CLS_YELLOW;
      end
    end
    return c;
  endfunction

  always_comb begin
    hue = in_tdata[7:0];
    sat = in_tdata[15:8];
    bri = in_tdata[23:16];
    cls = classify(hue, sat, bri);

    w_eff = CWX'(frame_width_r);
    if (frame_width_r == '0) begin
      w_eff = CWX'(1);
    end else if (CWX'(frame_width_r) > CWX'(MAX_WIDTH)) begin
      w_eff = CWX'(MAX_WIDTH);
    end
    h_eff = RWX'(frame_height_r);
    if (frame_height_r == '0) begin
      h_eff = RWX'(1);
    end else if (RWX'(frame_height_r) > RWX'(MAX_HEIGHT)) begin
      h_eff = RWX'(MAX_HEIGHT);
    end

    col_plus  = CWX'(col_r) + CWX'(1);
    row_plus  = RWX'(row_r) + RWX'(1);
    row_end   = col_plus >= w_eff;
    frame_end = row_end && (row_plus >= h_eff);

    col_nxt = row_end ? '0 : col_plus[CW-1:0];
    row_nxt = row_r;
    if (row_end) begin
      row_nxt = frame_end ? '0 : row_plus[RW-1:0];
    end

    in_tready         = !q_full;
    q_push            = in_tvalid && !q_full;
    q_info.cls        = cls;
    q_info.frame_end  = frame_end;
    q_col             = col_r;
    q_row             = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      if (cfg_wr_en && cfg_addr == REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_addr == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_wdata;
      end
      if (q_push) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[src/hcbc_fifo.sv]
// Short request queue between the front end and the back end.
// Depends on hcbc_pkg for its depth; data width set by the instantiating module.
`default_nettype none

module hcbc_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = hcbc_pkg::QDEPTH
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  wire  [DW-1:0] din,
  output logic          full,
  input  wire           pop,
  output logic [DW-1:0] dout,
  output logic          empty
);
  import hcbc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    full  = count_r == (AW + 1)'(DEPTH);
    empty = count_r == '0;
    dout  = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

[src/hcbc_div.sv]
// Restoring divider, one quotient bit per cycle, for the centroid means.
// Depends on hcbc_pkg for the sum and tally widths.
`default_nettype none

module hcbc_div (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [hcbc_pkg::SUM_W-1:0]       dividend,
  input  wire  [hcbc_pkg::TALLY_W-1:0]     divisor,
  output logic                             busy,
  output logic [hcbc_pkg::SUM_W-1:0]       quotient
);
  import hcbc_pkg::*;

  localparam int NW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [TALLY_W-1:0] rem_r, rem_nxt;
  logic [TALLY_W-1:0] div_r;
  logic [NW-1:0]      cnt_r;
  logic               busy_r;
  logic [TALLY_W:0]   trial, diff;
  logic               qbit;

  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    qbit    = trial >= {1'b0, div_r};
    rem_nxt = qbit ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], qbit};
    busy     = busy_r;
    quotient = quo_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + NW'(1);
      if (cnt_r == NW'(SUM_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/hcbc_back.sv]
// Back end: per-class accumulators, pixel results and the frame-end centroid pass.
// Depends on hcbc_pkg and hcbc_div; pops requests from the queue.
`default_nettype none

module hcbc_back #(
  parameter int CW = 11,
  parameter int RW = 11
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                q_empty,
  input  hcbc_pkg::pix_info_t                q_info,
  input  wire  [CW-1:0]                      q_col,
  input  wire  [RW-1:0]                      q_row,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [hcbc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import hcbc_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [CLS_IDX_W-1:0] k_r;
  logic [SUM_W-1:0]     sum_x_r [NUM_CLASSES];
  logic [SUM_W-1:0]     sum_y_r [NUM_CLASSES];
  logic [TALLY_W-1:0]   tally_r [NUM_CLASSES];
  logic [CLS_IDX_W-1:0] acc_idx;
  logic [SUM_W-1:0]     rd_sum_x, rd_sum_y;
  logic [TALLY_W-1:0]   rd_tally;

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic                 out_mask_r;
  cls_t                 out_cls_r;
  logic [CENT_W-1:0]    out_cx_r, out_cy_r;
  logic                 out_found_r, out_last_r;

  logic                 out_free, div_start, emit, last_cls, acc_clear, accum;
  logic                 busy_x, busy_y;
  logic [SUM_W-1:0]     quo_x, quo_y;

  hcbc_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_sum_x),
    .divisor  (rd_tally),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  hcbc_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_sum_y),
    .divisor  (rd_tally),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_comb begin
    acc_idx  = (state_r == ST_IDLE) ? CLS_IDX_W'(3'(q_info.cls) - 3'd1) : k_r;
    rd_sum_x = sum_x_r[acc_idx];
    rd_sum_y = sum_y_r[acc_idx];
    rd_tally = tally_r[acc_idx];
    out_free = !out_valid_r || out_tready;
    last_cls = k_r == CLS_IDX_W'(NUM_CLASSES - 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && q_info.frame_end) begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!busy_x) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_cls ? ST_IDLE : ST_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == ST_IDLE) && !q_empty && out_free;
    accum     = q_pop && (q_info.cls != CLS_NONE);
    div_start = state_r == ST_START;
    emit      = (state_r == ST_EMIT) && out_free;
    acc_clear = emit && last_cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        k_r <= last_cls ? '0 : k_r + CLS_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || acc_clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        tally_r[i] <= '0;
      end
    end else if (accum) begin
      sum_x_r[acc_idx] <= rd_sum_x + SUM_W'(q_col);
      sum_y_r[acc_idx] <= rd_sum_y + SUM_W'(q_row);
      tally_r[acc_idx] <= rd_tally + TALLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop || emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_kind_r  <= KIND_PIXEL;
      out_mask_r  <= q_info.cls != CLS_NONE;
      out_cls_r   <= q_info.cls;
      out_cx_r    <= '0;
      out_cy_r    <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= !q_info.frame_end;
    end else if (emit) begin
      out_kind_r  <= KIND_CENTROID;
      out_mask_r  <= 1'b0;
      out_cls_r   <= cls_t'(3'(k_r) + 3'd1);
      out_found_r <= rd_tally != '0;
      out_cx_r    <= (rd_tally != '0) ? quo_x[CENT_W-1:0] : '0;
      out_cy_r    <= (rd_tally != '0) ? quo_y[CENT_W-1:0] : '0;
      out_last_r  <= last_cls;
    end
  end

  always_comb begin
    out_tvalid = out_valid_r;
    out_tuser  = out_kind_r;
    out_tlast  = out_last_r;
    out_tdata  = OUT_DATA_W'({out_found_r, out_cy_r, out_cx_r, out_cls_r, out_mask_r});
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    busy_x == busy_y)
    else $error("centroid dividers out of step");

  a_mask_matches_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_PIXEL |-> out_mask_r == (out_cls_r != CLS_NONE))
    else $error("pixel mask disagrees with class");

  a_centroid_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_CENTROID |->
      (out_cls_r == CLS_BLUE || out_cls_r == CLS_GREEN ||
       out_cls_r == CLS_RED || out_cls_r == CLS_YELLOW) &&
      (out_last_r == (out_cls_r == CLS_YELLOW)))
    else $error("bad centroid class or last flag");

  a_empty_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_cx_r == '0 && out_cy_r == '0)
    else $error("empty class with nonzero centroid");

endmodule

`default_nettype wire

[src/hsv_color_blob_centroid_unit.sv]
// HSV color blob centroid unit: top level joining front end, queue and back end.
// Depends on hcbc_pkg, hcbc_front, hcbc_fifo and hcbc_back.
//
// Usage:
//   in_*  : one HSV pixel per request in raster order.
//   out_* : one pixel result (out_tuser = 0) per pixel; after the last pixel
//           of a frame four centroid results (out_tuser = 1) follow for blue,
//           green, red and yellow, the yellow one with out_tlast = 1.
//   cfg_* : frame width (index 0) and frame height (index 1); write while idle.
// Path: an accepted pixel is written into the queue, then popped into the output register.
// Throughput: one pixel per cycle while the queue has room. At a frame end the
//   back end runs two restoring dividers once per class; the 4-entry queue
//   then fills and in_tready stays low until the back end pops again after
//   the last centroid result is loaded.
// Reset: rst_n (synchronous) sets width 640, height 480, position (0,0) and
//   clears the accumulators, the queue and the output valid flag.
// Stall: a result waits in the output register while out_tready is low; the
//   front end keeps taking pixels until the queue is full.
`default_nettype none

module hsv_color_blob_centroid_unit #(
  parameter int MAX_WIDTH  = hcbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hcbc_pkg::MAX_HEIGHT_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire  [hcbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [hcbc_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [hcbc_pkg::IN_DATA_W-1:0]    in_tdata,   // hue, saturation, brightness
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [hcbc_pkg::OUT_DATA_W-1:0]   out_tdata,  // mask, color_class, centroid_x,
                                                        // centroid_y, found, zero pad
  output logic                              out_tuser,  // kind
  output logic                              out_tlast
);
  import hcbc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = $bits(pix_info_t) + CW + RW;

  logic          q_push, q_pop, q_full, q_empty;
  pix_info_t     f_info, b_info;
  logic [CW-1:0] f_col, b_col;
  logic [RW-1:0] f_row, b_row;
  logic [QW-1:0] q_din, q_dout;

  hcbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_info    (f_info),
    .q_col     (f_col),
    .q_row     (f_row)
  );

  assign q_din = {f_info, f_col, f_row};
  assign {b_info, b_col, b_row} = q_dout;

  hcbc_fifo #(
    .DW    (QW),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  hcbc_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_info     (b_info),
    .q_col      (b_col),
    .q_row      (b_row),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[tb/blob_centroid_checker.sv]
`timescale 1ns / 1ps
// Result checker for hsv_color_blob_centroid_unit: follows register writes and
// pixel requests, predicts pixel and centroid results and compares them.
// Depends on hcbc_pkg only.
module blob_centroid_checker #(
  parameter int MAX_W = hcbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_H = hcbc_pkg::MAX_HEIGHT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [hcbc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [hcbc_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire  [hcbc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire  [hcbc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire                              out_tuser,
  input  wire                              out_tlast,
  output int                               pending,
  output int                               fail_count,
  output int                               pixel_seen,
  output int                               centroid_seen,
  output int                               found_seen
);
  import hcbc_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic              mask;
    cls_t              cls;
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
    logic              found;
    logic              last;
  } blob_result_t;

  blob_result_t       want_q[$];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [SUM_W-1:0]   sum_x [NUM_CLASSES];
  logic [SUM_W-1:0]   sum_y [NUM_CLASSES];
  logic [TALLY_W-1:0] tally [NUM_CLASSES];
  int                 fails;
  int                 n_pix;
  int                 n_cent;
  int                 n_found;

  function automatic cls_t classify_pixel(input logic [7:0] h, input logic [7:0] s,
                                          input logic [7:0] v);
    if (v <= 8'd64) return CLS_NONE;
    if (h > 8'd90 && h < 8'd110 && s > 8'd120) return CLS_BLUE;
    if (h > 8'd60 && h < 8'd80 && s > 8'd120) return CLS_GREEN;
    if (((h > 8'd0 && h < 8'd5) || (h > 8'd160 && h < 8'd180)) && s > 8'd110)
      return CLS_RED;
    if (h > 8'd20 && h < 8'd30 && s > 8'd160) return CLS_YELLOW;
    return CLS_NONE;
  endfunction

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < NUM_CLASSES; i++) begin
      sum_x[i] = '0;
      sum_y[i] = '0;
      tally[i] = '0;
    end
  endtask

  task automatic flag_field(input string name, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    blob_result_t     r;
    cls_t             c;
    int unsigned      w;
    int unsigned      ht;
    int unsigned      k;
    logic             frame_end;
    logic [SUM_W-1:0] q;
    if (!rst_n) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      clear_sums();
      want_q.delete();
      fails   = 0;
      n_pix   = 0;
      n_cent  = 0;
      n_found = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_FRAME_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        c  = classify_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
        w  = eff_size(width_reg, MAX_W);
        ht = eff_size(height_reg, MAX_H);
        if (c != CLS_NONE) begin
          k = int'(c) - 1;
          sum_x[k] = sum_x[k] + col_pos;
          sum_y[k] = sum_y[k] + row_pos;
          tally[k] = tally[k] + 1'b1;
        end
        frame_end = 1'b0;
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          if (row_pos + 1 >= ht) begin
            row_pos   = 0;
            frame_end = 1'b1;
          end else begin
            row_pos++;
          end
        end else begin
          col_pos++;
        end
        r.kind  = KIND_PIXEL;
        r.mask  = (c != CLS_NONE);
        r.cls   = c;
        r.cx    = '0;
        r.cy    = '0;
        r.found = 1'b0;
        r.last  = !frame_end;
        want_q.push_back(r);
        if (frame_end) begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            r.kind = KIND_CENTROID;
            r.mask = 1'b0;
            r.cls  = cls_t'(i + 1);
            if (tally[i] != '0) begin
              q       = sum_x[i] / tally[i];
              r.cx    = q[CENT_W-1:0];
              q       = sum_y[i] / tally[i];
              r.cy    = q[CENT_W-1:0];
              r.found = 1'b1;
            end else begin
              r.cx    = '0;
              r.cy    = '0;
              r.found = 1'b0;
            end
            r.last = (i == NUM_CLASSES - 1);
            want_q.push_back(r);
          end
          clear_sums();
        end
      end
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
                   $time, out_tdata, out_tuser, out_tlast);
          fails++;
        end else begin
          r = want_q.pop_front();
          flag_field("kind", r.kind, out_tuser);
          flag_field("mask", r.mask, out_tdata[0]);
          flag_field("color_class", r.cls, out_tdata[3:1]);
          flag_field("centroid_x", r.cx, out_tdata[14:4]);
          flag_field("centroid_y", r.cy, out_tdata[25:15]);
          flag_field("found", r.found, out_tdata[26]);
          flag_field("last", r.last, out_tlast);
          flag_field("pad", 0, out_tdata[31:27]);
          if (r.kind == KIND_CENTROID) begin
            n_cent++;
            if (r.found) n_found++;
          end else begin
            n_pix++;
          end
        end
      end
    end
    pending       <= want_q.size();
    fail_count    <= fails;
    pixel_seen    <= n_pix;
    centroid_seen <= n_cent;
    found_seen    <= n_found;
  end

endmodule

[tb/hsv_color_blob_centroid_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the hsv_color_blob_centroid_unit testbench: clock, reset, register
// writes and pixel stimulus with random idling; verdict from blob_centroid_checker.
// Depends on hcbc_pkg, the block and tb/blob_centroid_checker.sv.
module hsv_color_blob_centroid_unit_tb;
  import hcbc_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tuser;
  wire                   out_tlast;

  int pending;
  int fail_count;
  int pixel_seen;
  int centroid_seen;
  int found_seen;
  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;
  int stall_left = 0;
  int sizes_used = 0;

  always #10 clk = ~clk;

  hsv_color_blob_centroid_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  blob_centroid_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .pending       (pending),
    .fail_count    (fail_count),
    .pixel_seen    (pixel_seen),
    .centroid_seen (centroid_seen),
    .found_seen    (found_seen)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_calm || $urandom_range(0, 99) < 65) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= idle_len() - 1;
    end
  end

  task automatic push_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, s, h};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_random_pixel();
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] hue_edges [20];
    logic [7:0] sat_edges [6];
    int         sel;
    hue_edges = '{0, 1, 4, 5, 20, 21, 29, 30, 60, 61, 79, 80, 90, 91, 109, 110,
                  160, 161, 179, 180};
    sat_edges = '{110, 111, 120, 121, 160, 161};
    sel = $urandom_range(0, 99);
    v   = 8'($urandom_range(65, 255));
    if (sel < 15) begin
      h = 8'($urandom_range(91, 109));
      s = 8'($urandom_range(121, 255));
    end else if (sel < 30) begin
      h = 8'($urandom_range(61, 79));
      s = 8'($urandom_range(121, 255));
    end else if (sel < 45) begin
      h = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 4)) :
                                        8'($urandom_range(161, 179));
      s = 8'($urandom_range(111, 255));
    end else if (sel < 58) begin
      h = 8'($urandom_range(21, 29));
      s = 8'($urandom_range(161, 255));
    end else if (sel < 75) begin
      h = hue_edges[$urandom_range(0, 19)];
      s = sat_edges[$urandom_range(0, 5)];
      v = ($urandom_range(0, 1) != 0) ? 8'd64 : 8'd65;
    end else begin
      h = 8'($urandom);
      s = 8'($urandom);
      v = 8'($urandom);
    end
    push_pixel(h, s, v);
  endtask

  // hold the sender until every predicted result is out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] ht);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, ht);
    sizes_used++;
  endtask

  initial begin
    #50_000_000;
    $display("hsv_color_blob_centroid_unit test failed");
    $finish;
  end

  initial begin
    logic [23:0] edge_px [24];
    int          sent;
    int          n;
    int          w;
    int          ht;
    edge_px = '{{8'd65, 8'd121, 8'd100}, {8'd255, 8'd255, 8'd91},
                {8'd128, 8'd200, 8'd109}, {8'd200, 8'd200, 8'd110},
                {8'd200, 8'd120, 8'd100}, {8'd64, 8'd200, 8'd100},
                {8'd65, 8'd121, 8'd70},   {8'd200, 8'd200, 8'd61},
                {8'd255, 8'd255, 8'd79},  {8'd200, 8'd200, 8'd60},
                {8'd200, 8'd200, 8'd80},  {8'd65, 8'd111, 8'd1},
                {8'd65, 8'd111, 8'd4},    {8'd200, 8'd200, 8'd0},
                {8'd200, 8'd200, 8'd5},   {8'd65, 8'd111, 8'd161},
                {8'd255, 8'd255, 8'd179}, {8'd200, 8'd200, 8'd160},
                {8'd200, 8'd200, 8'd180}, {8'd200, 8'd110, 8'd2},
                {8'd65, 8'd161, 8'd25},   {8'd255, 8'd255, 8'd29},
                {8'd255, 8'd255, 8'd20},  {8'd200, 8'd160, 8'd25}};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset frame size first, then small frames over the class boundaries
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd21, 8'd161, 8'd65);
    set_frame(12'd4, 12'd2);
    foreach (edge_px[i]) push_pixel(edge_px[i][7:0], edge_px[i][15:8], edge_px[i][23:16]);

    sent = 0;
    while (sent < 220) begin
      n  = $urandom_range(0, 9);
      w  = (n == 0) ? 0 : (n == 1) ? 1 : $urandom_range(2, 12);
      ht = $urandom_range(0, 4);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      set_frame(CFG_W'(w), CFG_W'(ht));
      n = $urandom_range(8, 40);
      repeat (n) push_random_pixel();
      sent += n;
    end

    // oversize and zero sizes, then shrink mid-frame
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    set_frame(12'd4095, 12'd0);
    repeat (16) push_random_pixel();
    set_frame(12'd0, 12'd4095);
    repeat (16) push_random_pixel();
    set_frame(12'd3, 12'd2);
    repeat (12) push_random_pixel();

    drain();
    repeat (300) @(posedge clk);
    $display("Covered %0d pixel results and %0d centroid results (%0d classes found)",
             pixel_seen, centroid_seen, found_seen);
    $display("over %0d frame size settings, including zero and oversize values.", sizes_used);
    if (fail_count == 0 && pending == 0) begin
      $display("hsv_color_blob_centroid_unit test passed");
    end else begin
      $display("hsv_color_blob_centroid_unit test failed");
    end
    $finish;
  end

endmodule
